/* src/aes128_pkg.sv */
// aes128_pkg: shared types, constants and byte functions for the aes-128 cipher unit
// no dependencies; used by the key schedule, the round cell and the top level of the cipher unit
package aes128_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned BlockW    = 128;
  localparam int unsigned KeyW      = 128;
  localparam int unsigned AddrW     = 4;

  typedef enum logic [AddrW-1:0] {
    RegKeyHigh = 4'h0,
    RegKeyLow  = 4'h8
  } reg_addr_e;

  typedef enum logic {
    OpEncrypt = 1'b0,
    OpDecrypt = 1'b1
  } op_e;

  typedef struct packed {
    logic             valid;
    logic             decrypt;
    logic [BlockW-1:0] state;
  } cell_bus_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

  // byte k of a 128-bit value, byte 0 in the top bits
  function automatic logic [7:0] get_byte(logic [127:0] v, int unsigned k);
    return v[127-8*k -: 8];
  endfunction

  function automatic logic [7:0] xtime(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // forward column mix: 02 03 01 01
  function automatic logic [31:0] mix_col(logic [31:0] c);
    logic [7:0] a0, a1, a2, a3;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
            a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
            a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
            xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
  endfunction

  // inverse column mix: pre-multiply by 04/05 then apply forward mix
  function automatic logic [31:0] inv_mix_col(logic [31:0] c);
    logic [7:0] a0, a1, a2, a3, u, v;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    u  = xtime(xtime(a0 ^ a2));
    v  = xtime(xtime(a1 ^ a3));
    return mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
  endfunction

  // one key schedule step, rcon given
  function automatic logic [127:0] next_key(logic [127:0] k, logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [7:0] rcon(int unsigned r);
    logic [7:0] rc;
    rc = 8'h01;
    for (int unsigned i = 1; i < 16; i++) begin
      if (i < r) rc = xtime(rc);
    end
    return rc;
  endfunction

endpackage

/* src/aes128_key_sched.sv */
// aes128_key_sched: expands the configured key into all round keys
// depends on aes128_pkg; round keys are registered, recomputed one step per cycle
module aes128_key_sched #(
  parameter int unsigned NumRounds = aes128_pkg::NumRounds
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [aes128_pkg::KeyW-1:0]   key_i,
  input  logic                          key_load_i,
  output logic                          keys_ready_o,
  output logic [aes128_pkg::KeyW-1:0]   round_key_o [NumRounds+1]
);

  localparam int unsigned CntW = $clog2(NumRounds + 2);

  logic [aes128_pkg::KeyW-1:0] rk_q [NumRounds+1];
  logic [CntW-1:0]             settle_q, settle_d;

  // each stage follows its predecessor, so a new key ripples through the stages in order after a key write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned r = 0; r <= NumRounds; r++) begin
        rk_q[r] <= '0;
      end
    end else begin
      rk_q[0] <= key_i;
      for (int unsigned r = 1; r <= NumRounds; r++) begin
        rk_q[r] <= aes128_pkg::next_key(rk_q[r-1], aes128_pkg::rcon(r));
      end
    end
  end

  // settle countdown, restarted by every key write and by reset
  always_comb begin
    settle_d = settle_q;
    if (key_load_i) begin
      settle_d = CntW'(NumRounds + 1);
    end else if (settle_q != '0) begin
      settle_d = settle_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= CntW'(NumRounds + 1);
    end else begin
      settle_q <= settle_d;
    end
  end

  assign keys_ready_o = (settle_q == '0);
  assign round_key_o  = rk_q;

endmodule

/* src/aes128_round_cell.sv */
// aes128_round_cell: one cipher round, encrypt or decrypt, registered at its output
// depends on aes128_pkg; chained by the top level
module aes128_round_cell #(
  parameter bit LastRound = 1'b0
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  aes128_pkg::cell_bus_t           cell_i,
  input  logic [aes128_pkg::BlockW-1:0]   enc_key_i,
  input  logic [aes128_pkg::BlockW-1:0]   dec_key_i,
  output aes128_pkg::cell_bus_t           cell_o
);

  logic [127:0] s, sub_e, sr_e, mc_e, res_e;
  logic [127:0] sr_d, sub_d, ark_d, res_d;
  aes128_pkg::cell_bus_t cell_d, cell_q;

  assign s = cell_i.state;

  // forward: sub bytes, shift rows, mix columns (skipped in the last round), add key
  always_comb begin
    for (int unsigned k = 0; k < 16; k++) begin
      sub_e[127-8*k -: 8] = aes128_pkg::SBOX[aes128_pkg::get_byte(s, k)];
    end
    for (int unsigned c = 0; c < 4; c++) begin
      for (int unsigned r = 0; r < 4; r++) begin
        sr_e[127-8*(4*c+r) -: 8] = aes128_pkg::get_byte(sub_e, 4*((c+r)%4)+r);
      end
    end
    for (int unsigned c = 0; c < 4; c++) begin
      mc_e[127-32*c -: 32] = aes128_pkg::mix_col(sr_e[127-32*c -: 32]);
    end
    res_e = (LastRound ? sr_e : mc_e) ^ enc_key_i;
  end

  // inverse: inv shift rows, inv sub bytes, add key, inv mix columns (skipped in the last round)
  always_comb begin
    for (int unsigned c = 0; c < 4; c++) begin
      for (int unsigned r = 0; r < 4; r++) begin
        sr_d[127-8*(4*((c+r)%4)+r) -: 8] = aes128_pkg::get_byte(s, 4*c+r);
      end
    end
    for (int unsigned k = 0; k < 16; k++) begin
      sub_d[127-8*k -: 8] = aes128_pkg::INV_SBOX[aes128_pkg::get_byte(sr_d, k)];
    end
    ark_d = sub_d ^ dec_key_i;
    for (int unsigned c = 0; c < 4; c++) begin
      res_d[127-32*c -: 32] = LastRound ? ark_d[127-32*c -: 32]
                                        : aes128_pkg::inv_mix_col(ark_d[127-32*c -: 32]);
    end
  end

  always_comb begin
    cell_d         = cell_i;
    cell_d.state   = cell_i.decrypt ? res_d : res_e;
  end

  // cell register, moves with the chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

/* src/aes128_block_cipher_unit.sv */
// aes128_block_cipher_unit: top level of the aes-128 ecb cipher
// depends on aes128_pkg, aes128_key_sched, aes128_round_cell
//
// AES-128 encrypt/decrypt through a chain of ten round cells plus an input
// key-add stage. Each cell holds one block, so one 128-bit block per cycle can
// be taken while the chain is not stalled and the round keys are settled; the
// whole chain advances whenever the output stage is free or taken, and a
// result that is not taken stalls the input. The key lives in two 64-bit
// registers (key_high at 0x0, key_low at 0x8); the round keys are pipelined from
// it, and the input is held off after reset and after every key write while
// they settle. Write the key only while no block is in flight.
module aes128_block_cipher_unit #(
  parameter int unsigned NumRounds = aes128_pkg::NumRounds
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // apb config
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [aes128_pkg::AddrW-1:0]      paddr,
  input  logic [63:0]                       pwdata,
  output logic [63:0]                       prdata,
  output logic                              pready,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [127:0]                      s_axis_tdata,  // block_high[63:0], block_low[127:64]
  input  logic                              s_axis_tuser,  // operation
  // output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [127:0]                      m_axis_tdata   // result_high[63:0], result_low[127:64]
);

  logic [63:0] key_high_q, key_low_q;
  logic [127:0] round_key [NumRounds+1];
  aes128_pkg::cell_bus_t chain [NumRounds+1];
  aes128_pkg::cell_bus_t in_d, in_q;
  logic adv;
  logic key_wr;
  logic keys_ready;

  assign pready = 1'b1;
  assign key_wr = psel && penable && pwrite && pready;

  // key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (key_wr) begin
      unique case (paddr)
        aes128_pkg::RegKeyHigh: key_high_q <= pwdata;
        aes128_pkg::RegKeyLow:  key_low_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      aes128_pkg::RegKeyHigh: prdata = key_high_q;
      aes128_pkg::RegKeyLow:  prdata = key_low_q;
      default:                prdata = '0;
    endcase
  end

  aes128_key_sched #(.NumRounds(NumRounds)) u_key_sched (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .key_i        ({key_high_q, key_low_q}),
    .key_load_i   (key_wr),
    .keys_ready_o (keys_ready),
    .round_key_o  (round_key)
  );

  // whole chain moves unless the output holds a result not yet taken
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv && keys_ready;

  // input stage: first key add
  always_comb begin
    in_d.valid   = s_axis_tvalid && keys_ready;
    in_d.decrypt = s_axis_tuser;
    in_d.state   = {s_axis_tdata[63:0], s_axis_tdata[127:64]} ^
                   (s_axis_tuser ? round_key[NumRounds] : round_key[0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q <= '0;
    end else if (adv) begin
      in_q <= in_d;
    end
  end

  assign chain[0] = in_q;

  // row of round cells
  for (genvar r = 1; r <= NumRounds; r++) begin : g_round
    aes128_round_cell #(.LastRound(r == NumRounds)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (adv),
      .cell_i    (chain[r-1]),
      .enc_key_i (round_key[r]),
      .dec_key_i (round_key[NumRounds-r]),
      .cell_o    (chain[r])
    );
  end

  assign m_axis_tvalid = chain[NumRounds].valid;
  assign m_axis_tdata  = {chain[NumRounds].state[63:0], chain[NumRounds].state[127:64]};

endmodule

/* src/aes128_checker.sv */
// aes128_checker: port-level assertions for the cipher unit
// depends on aes128_block_cipher_unit; attached by bind
module aes128_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic         pready
);

  // result held while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed under stall");

  // a waiting result blocks the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while a result waits");

  // config port never waits
  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

  // nothing comes out as reset is released
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result right after reset");

endmodule

bind aes128_block_cipher_unit aes128_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .pready        (pready)
);
